// ===== hdl/rational_arithmetic_unit_defines.svh =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_defines.svh
// Assertion macros for the rational arithmetic unit RTL.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTH
// checked on every edge outside reset
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define RAU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAU_ASSERT(lbl, prop, msg)
`define RAU_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Types, codes and the sequencer program of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int FW = 32;

  typedef struct packed {
    logic [1:0]    opcode;
    logic          lhs_negative;
    logic [FW-1:0] lhs_num;
    logic [FW-1:0] lhs_den;
    logic          rhs_negative;
    logic [FW-1:0] rhs_num;
    logic [FW-1:0] rhs_den;
  } rau_in_t;

  typedef struct packed {
    logic          res_negative;
    logic [FW-1:0] res_num;
    logic [FW-1:0] res_den;
    logic [1:0]    status;
  } rau_out_t;

  localparam logic [1:0] OPC_ADD = 2'd0;
  localparam logic [1:0] OPC_SUB = 2'd1;
  localparam logic [1:0] OPC_MUL = 2'd2;
  localparam logic [1:0] OPC_DIV = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DIV0 = 2'd1;
  localparam logic [1:0] STATUS_OVF  = 2'd2;

  // datapath registers
  localparam logic [3:0] R_N1 = 4'd0;
  localparam logic [3:0] R_D1 = 4'd1;
  localparam logic [3:0] R_N2 = 4'd2;
  localparam logic [3:0] R_D2 = 4'd3;
  localparam logic [3:0] R_G  = 4'd4;
  localparam logic [3:0] R_H  = 4'd5;
  localparam logic [3:0] R_X  = 4'd6;
  localparam logic [3:0] R_Y  = 4'd7;
  localparam logic [3:0] R_GA = 4'd8;
  localparam logic [3:0] R_GB = 4'd9;

  // datapath commands
  localparam logic [3:0] DP_NOP    = 4'd0;
  localparam logic [3:0] DP_LOAD   = 4'd1;
  localparam logic [3:0] DP_MOV    = 4'd2;
  localparam logic [3:0] DP_MUL    = 4'd3;
  localparam logic [3:0] DP_DIV    = 4'd4;
  localparam logic [3:0] DP_MOD    = 4'd5;
  localparam logic [3:0] DP_GINIT  = 4'd6;
  localparam logic [3:0] DP_GDONE  = 4'd7;
  localparam logic [3:0] DP_ADDSUB = 4'd8;
  localparam logic [3:0] DP_EMIT   = 4'd9;

  // program step kinds
  localparam logic [2:0] U_GCD    = 3'd0;
  localparam logic [2:0] U_DIV    = 3'd1;
  localparam logic [2:0] U_MUL    = 3'd2;
  localparam logic [2:0] U_MOV    = 3'd3;
  localparam logic [2:0] U_BR     = 3'd4;
  localparam logic [2:0] U_ADDSUB = 3'd5;
  localparam logic [2:0] U_END    = 3'd6;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_SWAP = 5'd7;
  localparam logic [PC_W-1:0] PC_MUL  = 5'd10;
  localparam logic [PC_W-1:0] PC_END  = 5'd18;
  localparam logic [PC_W-1:0] PC_ADD  = 5'd19;
  localparam logic [PC_W-1:0] PC_LAST = 5'd29;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] dst;
  } uop_t;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] dst;
  } dp_cmd_t;

  typedef struct packed {
    logic       div0;
    logic       ga_zero;
    logic       gb_zero;
    logic       ga_gt_gb;
    logic       div_done;
    logic       carry;
    logic [1:0] opcode;
  } dp_stat_t;

  // sequencer program
  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{kind: U_END, a: R_N1, b: R_N1, dst: R_N1};
    unique case (pc)
      5'd0:  u = '{kind: U_GCD,    a: R_N1, b: R_D1, dst: R_G};
      5'd1:  u = '{kind: U_DIV,    a: R_N1, b: R_G,  dst: R_N1};
      5'd2:  u = '{kind: U_DIV,    a: R_D1, b: R_G,  dst: R_D1};
      5'd3:  u = '{kind: U_GCD,    a: R_N2, b: R_D2, dst: R_G};
      5'd4:  u = '{kind: U_DIV,    a: R_N2, b: R_G,  dst: R_N2};
      5'd5:  u = '{kind: U_DIV,    a: R_D2, b: R_G,  dst: R_D2};
      5'd6:  u = '{kind: U_BR,     a: R_N1, b: R_N1, dst: R_N1};
      5'd7:  u = '{kind: U_MOV,    a: R_N2, b: R_N2, dst: R_H};
      5'd8:  u = '{kind: U_MOV,    a: R_D2, b: R_D2, dst: R_N2};
      5'd9:  u = '{kind: U_MOV,    a: R_H,  b: R_H,  dst: R_D2};
      5'd10: u = '{kind: U_GCD,    a: R_N1, b: R_D2, dst: R_G};
      5'd11: u = '{kind: U_GCD,    a: R_N2, b: R_D1, dst: R_H};
      5'd12: u = '{kind: U_DIV,    a: R_N1, b: R_G,  dst: R_N1};
      5'd13: u = '{kind: U_DIV,    a: R_D2, b: R_G,  dst: R_D2};
      5'd14: u = '{kind: U_DIV,    a: R_N2, b: R_H,  dst: R_N2};
      5'd15: u = '{kind: U_DIV,    a: R_D1, b: R_H,  dst: R_D1};
      5'd16: u = '{kind: U_MUL,    a: R_N1, b: R_N2, dst: R_N1};
      5'd17: u = '{kind: U_MUL,    a: R_D1, b: R_D2, dst: R_D1};
      5'd18: u = '{kind: U_END,    a: R_N1, b: R_N1, dst: R_N1};
      5'd19: u = '{kind: U_GCD,    a: R_D1, b: R_D2, dst: R_G};
      5'd20: u = '{kind: U_DIV,    a: R_D1, b: R_G,  dst: R_X};
      5'd21: u = '{kind: U_DIV,    a: R_D2, b: R_G,  dst: R_Y};
      5'd22: u = '{kind: U_MUL,    a: R_N1, b: R_Y,  dst: R_N1};
      5'd23: u = '{kind: U_MUL,    a: R_N2, b: R_X,  dst: R_N2};
      5'd24: u = '{kind: U_ADDSUB, a: R_N1, b: R_N2, dst: R_N1};
      5'd25: u = '{kind: U_GCD,    a: R_N1, b: R_G,  dst: R_H};
      5'd26: u = '{kind: U_DIV,    a: R_N1, b: R_H,  dst: R_N1};
      5'd27: u = '{kind: U_DIV,    a: R_D2, b: R_H,  dst: R_D2};
      5'd28: u = '{kind: U_MUL,    a: R_X,  b: R_D2, dst: R_D1};
      5'd29: u = '{kind: U_END,    a: R_N1, b: R_N1, dst: R_N1};
      default: u = '{kind: U_END,  a: R_N1, b: R_N1, dst: R_N1};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div #(
  parameter int WIDTH = 65
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic [WIDTH-1:0]      quotient,
  output logic [WIDTH-1:0]      remainder
);

  localparam int CW = $clog2(WIDTH);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH:0]   sh;
  logic [WIDTH:0]   diff;
  logic             ge;

  always_comb begin
    sh   = {remainder, quotient[WIDTH-1]};
    diff = sh - {1'b0, dvs};
    ge   = ~diff[WIDTH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      remainder <= ge ? diff[WIDTH-1:0] : sh[WIDTH-1:0];
      quotient  <= {quotient[WIDTH-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand registers, multiplier, add/subtract, divider, result.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_dp #(
  parameter int MAG_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rau_pkg::rau_in_t  in_data,
  input  wire rau_pkg::dp_cmd_t  cmd,
  output rau_pkg::dp_stat_t      stat,
  output rau_pkg::rau_out_t      out_data
);
  import rau_pkg::*;

  localparam int DW = 2 * MAG_WIDTH + 1;

  logic [DW-1:0] n1, d1, n2, d2, g, h, x, y, ga, gb;
  logic [1:0]    opcode;
  logic          s1, s2, sign, div0, ovf;
  logic [3:0]    pend_dst;
  logic          pend_rem;

  logic [DW-1:0] va, vb;
  logic [2*MAG_WIDTH-1:0] prod;
  logic [64:0]   sum65;
  logic          add_carry;
  logic [DW-1:0] t;
  logic          t_sign;
  logic          s2e;
  logic          wr_en;
  logic [3:0]    wr_sel;
  logic [DW-1:0] wr_data;
  logic          div_start, div_done;
  logic [DW-1:0] quo, rem;
  logic [DW-1:0] mask;
  rau_out_t      res;

  function automatic logic [DW-1:0] rd_reg(input logic [3:0] sel,
      input logic [DW-1:0] r0, r1, r2, r3, r4, r5, r6, r7, r8, r9);
    logic [DW-1:0] v;
    unique case (sel)
      R_N1: v = r0;
      R_D1: v = r1;
      R_N2: v = r2;
      R_D2: v = r3;
      R_G:  v = r4;
      R_H:  v = r5;
      R_X:  v = r6;
      R_Y:  v = r7;
      R_GA: v = r8;
      R_GB: v = r9;
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    va   = rd_reg(cmd.a, n1, d1, n2, d2, g, h, x, y, ga, gb);
    vb   = rd_reg(cmd.b, n1, d1, n2, d2, g, h, x, y, ga, gb);
    prod = va[MAG_WIDTH-1:0] * vb[MAG_WIDTH-1:0];
    mask = DW'({MAG_WIDTH{1'b1}});
  end

  // signed add/subtract of n1 and n2 in sign-magnitude form;
  // only a true addition can carry out of 64 bits
  always_comb begin
    s2e       = s2 ^ (opcode == OPC_SUB);
    sum65     = 65'(n1) + 65'(n2);
    add_carry = (s1 == s2e) && sum65[64];
    if (s1 == s2e) begin
      t      = n1 + n2;
      t_sign = s1;
    end else if (n1 >= n2) begin
      t      = n1 - n2;
      t_sign = s1;
    end else begin
      t      = n2 - n1;
      t_sign = s2e;
    end
  end

  assign div_start = (cmd.op == DP_DIV) || (cmd.op == DP_MOD);

  rau_div #(.WIDTH(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (va),
    .divisor   (vb),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_sel  = cmd.dst;
    wr_data = va;
    if (div_done) begin
      wr_en   = 1'b1;
      wr_sel  = pend_dst;
      wr_data = pend_rem ? rem : quo;
    end else begin
      unique case (cmd.op)
        DP_MOV:    wr_en = 1'b1;
        DP_MUL: begin
          wr_en   = 1'b1;
          wr_data = DW'(prod);
        end
        DP_GDONE: begin
          wr_en   = 1'b1;
          wr_data = ga | gb;
        end
        DP_ADDSUB: begin
          wr_en   = 1'b1;
          wr_sel  = R_N1;
          wr_data = t;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      opcode <= in_data.opcode;
      s1     <= in_data.lhs_negative;
      s2     <= in_data.rhs_negative;
      sign   <= in_data.lhs_negative ^ in_data.rhs_negative;
      n1     <= DW'(in_data.lhs_num[MAG_WIDTH-1:0]);
      d1     <= DW'(in_data.lhs_den[MAG_WIDTH-1:0]);
      n2     <= DW'(in_data.rhs_num[MAG_WIDTH-1:0]);
      d2     <= DW'(in_data.rhs_den[MAG_WIDTH-1:0]);
      div0   <= (in_data.lhs_den[MAG_WIDTH-1:0] == '0)
             || (in_data.rhs_den[MAG_WIDTH-1:0] == '0)
             || ((in_data.opcode == OPC_DIV) && (in_data.rhs_num[MAG_WIDTH-1:0] == '0));
      ovf    <= 1'b0;
    end else begin
      if (cmd.op == DP_ADDSUB) begin
        sign <= t_sign;
        ovf  <= add_carry;
      end
      if (cmd.op == DP_GINIT) begin
        ga <= va;
        gb <= vb;
      end
      if (wr_en) begin
        unique case (wr_sel)
          R_N1: n1 <= wr_data;
          R_D1: d1 <= wr_data;
          R_N2: n2 <= wr_data;
          R_D2: d2 <= wr_data;
          R_G:  g  <= wr_data;
          R_H:  h  <= wr_data;
          R_X:  x  <= wr_data;
          R_Y:  y  <= wr_data;
          R_GA: ga <= wr_data;
          R_GB: gb <= wr_data;
          default: ;
        endcase
      end
    end
    if (div_start) begin
      pend_dst <= cmd.dst;
      pend_rem <= (cmd.op == DP_MOD);
    end
  end

  always_comb begin
    stat.div0     = div0;
    stat.ga_zero  = (ga == '0);
    stat.gb_zero  = (gb == '0);
    stat.ga_gt_gb = (ga > gb);
    stat.div_done = div_done;
    stat.carry    = add_carry;
    stat.opcode   = opcode;
  end

  always_comb begin
    res = '{res_negative: 1'b0, res_num: '0, res_den: FW'(1), status: STATUS_OK};
    if (div0) begin
      res.status = STATUS_DIV0;
    end else if (ovf) begin
      res.status = STATUS_OVF;
    end else if (n1 == '0) begin
      res.status = STATUS_OK;
    end else if ((n1 > mask) || (d1 > mask)) begin
      res.status = STATUS_OVF;
    end else begin
      res.res_negative = sign;
      res.res_num      = FW'(n1[MAG_WIDTH-1:0]);
      res.res_den      = FW'(d1[MAG_WIDTH-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: walks the operation program and runs the Euclid loops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"

module rau_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rau_pkg::dp_cmd_t       cmd,
  input  wire rau_pkg::dp_stat_t stat
);
  import rau_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_GCDW = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]      state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  uop_t            u;

  assign u        = uop_rom(pc);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    pc_next    = pc;
    cmd        = '{op: DP_NOP, a: u.a, b: u.b, dst: u.dst};
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        pc_next    = '0;
        state_next = stat.div0 ? S_OUT : S_RUN;
      end
      S_RUN: begin
        unique case (u.kind)
          U_GCD: begin
            cmd.op     = DP_GINIT;
            state_next = S_GCD;
          end
          U_DIV: begin
            cmd.op     = DP_DIV;
            state_next = S_DIVW;
          end
          U_MUL: begin
            cmd.op  = DP_MUL;
            pc_next = pc + 1'b1;
          end
          U_MOV: begin
            cmd.op  = DP_MOV;
            pc_next = pc + 1'b1;
          end
          U_ADDSUB: begin
            cmd.op  = DP_ADDSUB;
            pc_next = stat.carry ? PC_END : pc + 1'b1;
          end
          U_BR: begin
            priority if (stat.opcode == OPC_MUL) begin
              pc_next = PC_MUL;
            end else if (stat.opcode == OPC_DIV) begin
              pc_next = PC_SWAP;
            end else begin
              pc_next = PC_ADD;
            end
          end
          default: state_next = S_OUT;
        endcase
      end
      S_DIVW: begin
        if (stat.div_done) begin
          pc_next    = pc + 1'b1;
          state_next = S_RUN;
        end
      end
      S_GCD: begin
        if (stat.ga_zero || stat.gb_zero) begin
          cmd.op     = DP_GDONE;
          pc_next    = pc + 1'b1;
          state_next = S_RUN;
        end else begin
          cmd.op     = DP_MOD;
          state_next = S_GCDW;
          if (stat.ga_gt_gb) begin
            cmd.a   = R_GA;
            cmd.b   = R_GB;
            cmd.dst = R_GA;
          end else begin
            cmd.a   = R_GB;
            cmd.b   = R_GA;
            cmd.dst = R_GB;
          end
        end
      end
      S_GCDW: begin
        if (stat.div_done) begin
          state_next = S_GCD;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = DP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (cmd.op == DP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `RAU_ASSERT(a_load_to_check, (in_valid && in_ready) |=> (state == S_CHK), "load did not reach check")
  `RAU_ASSERT(a_emit_slot_free, (cmd.op == DP_EMIT) |-> (!out_valid || out_ready), "result overwritten")
  `RAU_ASSERT(a_pc_in_program, (state == S_RUN) |-> (pc <= PC_LAST), "program counter out of range")
  `RAU_ASSERT(a_wait_is_quiet, (state == S_DIVW || state == S_GCDW) |-> (cmd.op == DP_NOP), "command during divide")
  `RAU_ASSERT_RST(a_reset_idle, (!rst && $past(rst)) |-> (state == S_IDLE && !out_valid), "not idle after reset")

endmodule

`default_nettype wire

// ===== hdl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add/subtract/multiply/divide of sign-magnitude fractions, GCD reduced.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_ready/in_data carries opcode and both operands;
//    a transfer happens when in_valid and in_ready are high at a clock edge.
//  - Output channel out_valid/out_ready/out_data carries one reduced result
//    (sign, numerator, denominator, status) per input transfer, in order.
//  - One item is worked on at a time. in_ready is high only while the
//    sequencer is idle; it may take the next item while the previous result
//    still sits in the output register waiting for out_ready.
//  - Latency is data dependent. Every division and every Euclid modulo step
//    runs through one shared restoring divider of 2*MAG_WIDTH+1 bits, one
//    quotient bit a cycle. An item without error runs at least eight
//    divisions; long Euclid chains on full-width operands take the longest.
//    A zero denominator skips the program: the sequencer goes from the
//    check state straight to the output state, which raises out_valid.
//  - If the receiver stalls, the finished result is held in the output
//    register and the next computed result waits until that one transfers.
//  - Reset (rst, synchronous) returns the sequencer to idle and drops
//    out_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit #(
  parameter int MAG_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rau_pkg::rau_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rau_pkg::rau_out_t     out_data
);
  import rau_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: handshakes, operation program, Euclid loop control
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: operand registers, multiplier, divider, result register
  rau_dp #(.MAG_WIDTH(MAG_WIDTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/sv/rau_result_checker.sv =====
// ----------------------------------------------------------------------------
// rau_result_checker
// Watches both channels of the rational arithmetic unit, computes the exact
// reduced fraction for every input transfer and compares each output transfer
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
module rau_result_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  rau_pkg::rau_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  rau_pkg::rau_out_t out_data,
  output int unsigned       mismatches,
  output int unsigned       pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  localparam logic [63:0] MAG_MAX = 64'h0000_0000_FFFF_FFFF;

  rau_out_t results_due[$];

  initial mismatches = 0;
  initial pending = 0;

  function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
    while (a != 0 && b != 0) begin
      if (a > b) a = a % b;
      else       b = b % a;
    end
    return a + b;
  endfunction

  // exact rational result, reduced; error results carry 0/1
  function automatic rau_out_t rational_result(rau_in_t x);
    logic [63:0] n1, d1, n2, d2, g, g1, g2, rn, rd, a, b, t, d1r, d2r, tmp;
    logic [64:0] sum;
    logic s1, s2, rs;
    rau_out_t r;
    r = '{res_negative: 1'b0, res_num: '0, res_den: 32'd1, status: STATUS_OK};
    n1 = x.lhs_num; d1 = x.lhs_den; s1 = x.lhs_negative;
    n2 = x.rhs_num; d2 = x.rhs_den; s2 = x.rhs_negative;
    if (d1 == 0 || d2 == 0 || (x.opcode == OPC_DIV && n2 == 0)) begin
      r.status = STATUS_DIV0;
      return r;
    end
    g = euclid_gcd(n1, d1); n1 = n1 / g; d1 = d1 / g;
    g = euclid_gcd(n2, d2); n2 = n2 / g; d2 = d2 / g;
    if (x.opcode == OPC_MUL || x.opcode == OPC_DIV) begin
      if (x.opcode == OPC_DIV) begin
        tmp = n2; n2 = d2; d2 = tmp;
      end
      g1 = euclid_gcd(n1, d2);
      g2 = euclid_gcd(n2, d1);
      rn = (n1 / g1) * (n2 / g2);
      rd = (d1 / g2) * (d2 / g1);
      rs = s1 ^ s2;
    end else begin
      if (x.opcode == OPC_SUB) s2 = ~s2;
      g = euclid_gcd(d1, d2);
      d1r = d1 / g;
      d2r = d2 / g;
      a = n1 * d2r;
      b = n2 * d1r;
      if (s1 == s2) begin
        sum = {1'b0, a} + {1'b0, b};
        if (sum[64]) begin
          r.status = STATUS_OVF;
          return r;
        end
        t = sum[63:0];
        rs = s1;
      end else if (a >= b) begin
        t = a - b; rs = s1;
      end else begin
        t = b - a; rs = s2;
      end
      g2 = euclid_gcd(t, g);
      if (g2 == 0) g2 = 1;
      rn = t / g2;
      rd = d1r * (d2 / g2);
    end
    if (rn == 0) return r;
    if (rn > MAG_MAX || rd > MAG_MAX) begin
      r.status = STATUS_OVF;
      return r;
    end
    r.res_negative = rs;
    r.res_num = rn[31:0];
    r.res_den = rd[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    rau_out_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        results_due.insert(results_due.size(), rational_result(in_data));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", out_data);
        end else begin
          want = results_due.pop_front();
          if (out_data.res_negative !== want.res_negative ||
              out_data.res_num !== want.res_num ||
              out_data.res_den !== want.res_den ||
              out_data.status !== want.status) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("result mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
      pending <= results_due.size();
    end
  end

endmodule

// ===== tb/sv/tb_rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Stimulus and verdict for the rational arithmetic unit: directed corner
// operands, then randomized fractions with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  rau_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rau_out_t    out_data;
  int unsigned mismatches;
  int unsigned pending;

  // idling knob shared by both sides; off means back-to-back transfers
  bit idle_on = 1'b1;
  // set by stimulus to make the receiver hold off for a long stretch
  bit long_hold = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rational_arithmetic_unit #(.MAG_WIDTH(32)) u_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

  rau_result_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .mismatches, .pending
  );

  // Drive one operand set and hold it until the transfer.
  task automatic send_operands(rau_in_t item);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_fraction_pair(logic [1:0] op, logic ls, logic [31:0] ln,
                                    logic [31:0] ld, logic rs, logic [31:0] rn,
                                    logic [31:0] rd);
    rau_in_t item;
    item = '{opcode: op, lhs_negative: ls, lhs_num: ln, lhs_den: ld,
             rhs_negative: rs, rhs_num: rn, rhs_den: rd};
    send_operands(item);
  endtask

  // Mostly small magnitudes keep the Euclid loops short; a share of full-width
  // values toggles every bit.
  function automatic logic [31:0] rand_magnitude();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(1, 255);
    if (pick < 75) return $urandom_range(0, 65535);
    if (pick < 92) return $urandom;
    return 32'd0;
  endfunction

  function automatic logic [31:0] rand_denominator();
    logic [31:0] d;
    d = rand_magnitude();
    // keep most denominators nonzero so the full datapath runs
    if (d == 0 && $urandom_range(0, 9) != 0) d = 32'd1;
    return d;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (20000) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog for a hung unit.
  initial begin
    #400_000_000;
    $display("rational_arithmetic_unit verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed corners ---
    // plain cases, one per operation
    send_fraction_pair(OPC_ADD, 1'b0, 32'd1, 32'd2, 1'b0, 32'd1, 32'd3);
    send_fraction_pair(OPC_SUB, 1'b0, 32'd1, 32'd2, 1'b0, 32'd3, 32'd4);
    send_fraction_pair(OPC_MUL, 1'b1, 32'd6, 32'd4, 1'b0, 32'd2, 32'd9);
    send_fraction_pair(OPC_DIV, 1'b1, 32'd3, 32'd5, 1'b1, 32'd9, 32'd10);
    // zero denominator on either side
    send_fraction_pair(OPC_ADD, 1'b0, 32'd1, 32'd0, 1'b0, 32'd1, 32'd3);
    send_fraction_pair(OPC_MUL, 1'b1, 32'd1, 32'd3, 1'b1, 32'd7, 32'd0);
    // divide by a zero fraction
    send_fraction_pair(OPC_DIV, 1'b0, 32'd5, 32'd7, 1'b1, 32'd0, 32'd9);
    // zero results must come out positive with denominator one
    send_fraction_pair(OPC_SUB, 1'b1, 32'd3, 32'd4, 1'b1, 32'd6, 32'd8);
    send_fraction_pair(OPC_MUL, 1'b1, 32'd0, 32'd5, 1'b0, 32'd3, 32'd7);
    send_fraction_pair(OPC_ADD, 1'b1, 32'd0, 32'd5, 1'b1, 32'd0, 32'd2);
    // opposite signs, both orderings of magnitude
    send_fraction_pair(OPC_ADD, 1'b0, 32'd1, 32'd3, 1'b1, 32'd1, 32'd2);
    send_fraction_pair(OPC_SUB, 1'b1, 32'd5, 32'd3, 1'b1, 32'd1, 32'd2);
    // overflow after reduction
    send_fraction_pair(OPC_MUL, 1'b0, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'hFFFF_FFFF, 32'd1);
    send_fraction_pair(OPC_ADD, 1'b0, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'd1, 32'd1);
    send_fraction_pair(OPC_DIV, 1'b0, 32'd1, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFE, 32'd1);
    // cross-multiplied sum wraps 64 bits
    send_fraction_pair(OPC_ADD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                       1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFD);
    send_fraction_pair(OPC_SUB, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                       1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFD);
    // full-width operands: the subtraction overflows, the division and product stay in range
    send_fraction_pair(OPC_SUB, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_fraction_pair(OPC_DIV, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                       1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_fraction_pair(OPC_MUL, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
                       1'b1, 32'h7FFF_FFFF, 32'h8000_0000);

    // sender pause: let every pending result drain
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);

    // --- random phase ---
    // long receiver hold-off while the sender keeps offering
    long_hold = 1'b1;
    for (int i = 0; i < 1380; i++) begin
      if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i == 700) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      send_fraction_pair(2'($urandom_range(0, 3)), 1'($urandom),
                         rand_magnitude(), rand_denominator(),
                         1'($urandom), rand_magnitude(), rand_denominator());
    end
    in_valid <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("rational_arithmetic_unit verification clean");
    end else begin
      $display("rational_arithmetic_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rau_pkg.sv
hdl/rau_div.sv
hdl/rau_dp.sv
hdl/rau_ctrl.sv
hdl/rational_arithmetic_unit.sv
tb/sv/rau_result_checker.sv
tb/sv/tb_rational_arithmetic_unit.sv
